// ===== src/fcbf_pkg.sv =====
// ----------------------------------------------------------------------------
// fcbf_pkg
// Shared types, constants and helper functions of the free class bitmap finder.
// ----------------------------------------------------------------------------
`default_nettype none

package fcbf_pkg;

  // bitmap word geometry
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned WORD_LSB  = 6;

  // field widths
  localparam int unsigned SIZE_W  = 40;
  localparam int unsigned CLASS_W = 11;

  // operation codes carried in tuser
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_LOOK,
    ST_FIRST,
    ST_NEXT,
    ST_SETRD,
    ST_EMIT
  } state_e;

  // position of the highest set bit, zero for a zero value
  function automatic logic [5:0] top_bit_pos(input logic [SIZE_W-1:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  // position of the lowest set bit, 63 for a zero word
  function automatic logic [5:0] low_bit_pos(input logic [WORD_BITS-1:0] v);
    logic [5:0] p;
    p = 6'(WORD_BITS - 1);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== src/free_class_bitmap_finder.sv =====
// ----------------------------------------------------------------------------
// free_class_bitmap_finder
// Size-class occupancy index of a segregated-fit allocator.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser selects the operation, set (0) or find (1).
// A set transaction writes one class bit as nonempty or empty; a find
// transaction maps request_size to its class and looks for the lowest
// nonempty class at or above it. Every input transaction yields exactly one
// output transaction (m_axis) carrying size_class and free_class in tdata and
// found in tuser; set transactions return all zeros.
// One item is in flight at a time. The bitmap lives in a RAM of 64-bit words
// with a registered read; a register of word-nonempty bits steers the search.
// A set passes through capture, a read of its word, the modify-write and the
// output load; a set to a class out of range skips the read and write. A find
// passes through class calculation and a lookup in the word-nonempty bits; it
// then reads the class word if it is nonempty, a later word if the class word
// has nothing at or above the class, or no word if the nonempty bits settle it.
// s_axis_tready returns once the result has been loaded.
// Reset clears the word-nonempty bits, which makes the whole bitmap read as
// empty at once; no clearing pass runs. A stalled receiver holds the result in
// the output register; the next item is still accepted and worked on, and
// waits before its own result is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module free_class_bitmap_finder #(
  parameter int unsigned SUB_BITS    = 4,
  parameter int unsigned CLASS_COUNT = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input transaction
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [39:0] request_size, [50:40] class_index, [51] class_nonempty, [55:52] zero
  input  wire logic [55:0] s_axis_tdata,
  // [0] op
  input  wire logic [0:0]  s_axis_tuser,
  // result transaction
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [10:0] size_class, [21:11] free_class, [23:22] zero
  output logic      [23:0] m_axis_tdata,
  // [0] found
  output logic      [0:0]  m_axis_tuser
);

  import fcbf_pkg::*;

  localparam int unsigned WORD_COUNT = (CLASS_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WA         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned SUB_W      = (SUB_BITS > 0) ? SUB_BITS : 1;
  localparam logic [SUB_W-1:0] SUB_MASK = SUB_W'((1 << SUB_BITS) - 1);

  state_e state_q, state_d;

  // captured item
  logic               op_q;
  logic [SIZE_W-1:0]  size_q;
  logic [CLASS_W-1:0] idx_q;
  logic               nonempty_q;

  // working registers
  logic [CLASS_W-1:0]    class_q, class_d;
  logic [WA-1:0]         word_q, word_d;
  logic [WORD_COUNT-1:0] summary_q, summary_d;
  logic [CLASS_W-1:0]    res_class_q, res_class_d;
  logic                  res_found_q, res_found_d;
  logic [CLASS_W-1:0]    res_free_q, res_free_d;

  // output register
  logic               m_valid_q, m_valid_d;
  logic [CLASS_W-1:0] m_class_q;
  logic               m_found_q;
  logic [CLASS_W-1:0] m_free_q;
  logic               out_load;

  // ram ports
  logic                 ram_we;
  logic [WA-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WA-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic s_accept;

  // size to class mapping
  logic [5:0]         top_pos;
  logic [SIZE_W-1:0]  shifted;
  logic [SUB_W-1:0]   sub_frac;
  logic [CLASS_W-1:0] class_calc;

  // word selection
  logic [5:0]    cls_word6, set_word6;
  logic [WA-1:0] cls_word, set_word;
  logic [5:0]    cls_bit;
  logic          cls_in_range, set_in_range;

  // search over the word-nonempty bits above the class word
  logic          next_any;
  logic [WA-1:0] next_word;

  // word data paths
  logic [WORD_BITS-1:0] first_masked;
  logic [WORD_BITS-1:0] old_word, set_mask, new_word;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // class of the captured size: top bit, then the sub-class fraction below it
  always_comb begin
    top_pos = top_bit_pos(size_q);
    if (top_pos >= 6'(SUB_BITS)) begin
      shifted = size_q >> (top_pos - 6'(SUB_BITS));
    end else begin
      shifted = size_q << (6'(SUB_BITS) - top_pos);
    end
    sub_frac = shifted[SUB_W-1:0] & SUB_MASK;
    if (size_q == '0) begin
      class_calc = '0;
    end else begin
      class_calc = (CLASS_W'(top_pos) << SUB_BITS) + CLASS_W'(sub_frac);
    end
  end

  // word and bit positions of the class and of the set index
  assign cls_word6    = {1'b0, class_q[CLASS_W-1:WORD_LSB]};
  assign set_word6    = {1'b0, idx_q[CLASS_W-1:WORD_LSB]};
  assign cls_word     = cls_word6[WA-1:0];
  assign set_word     = set_word6[WA-1:0];
  assign cls_bit      = class_q[WORD_LSB-1:0];
  assign cls_in_range = ({2'b00, class_q} < 13'(CLASS_COUNT));
  assign set_in_range = ({2'b00, idx_q} < 13'(CLASS_COUNT));

  // lowest nonempty word above the class word
  always_comb begin
    next_any  = 1'b0;
    next_word = '0;
    for (int i = WORD_COUNT - 1; i >= 0; i--) begin
      if (summary_q[i] && (WA'(i) > cls_word)) begin
        next_any  = 1'b1;
        next_word = WA'(i);
      end
    end
  end

  // first word masked to the class bit and above; read-modify of the set word
  assign first_masked = ram_rdata & ({WORD_BITS{1'b1}} << cls_bit);
  assign old_word     = summary_q[set_word] ? ram_rdata : '0;
  assign set_mask     = WORD_BITS'(1) << idx_q[WORD_LSB-1:0];
  assign new_word     = nonempty_q ? (old_word | set_mask) : (old_word & ~set_mask);

  // sequencer
  always_comb begin
    state_d     = state_q;
    class_d     = class_q;
    word_d      = word_q;
    summary_d   = summary_q;
    res_class_d = res_class_q;
    res_found_d = res_found_q;
    res_free_d  = res_free_q;
    ram_we      = 1'b0;
    ram_waddr   = set_word;
    ram_wdata   = new_word;
    ram_re      = 1'b0;
    ram_raddr   = cls_word;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        res_class_d = '0;
        res_found_d = 1'b0;
        res_free_d  = '0;
        if (op_q == OP_SET) begin
          if (set_in_range) begin
            ram_re    = 1'b1;
            ram_raddr = set_word;
            state_d   = ST_SETRD;
          end else begin
            state_d = ST_EMIT;
          end
        end else begin
          class_d = class_calc;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        res_class_d = class_q;
        if (!cls_in_range) begin
          state_d = ST_EMIT;
        end else if (summary_q[cls_word]) begin
          ram_re    = 1'b1;
          ram_raddr = cls_word;
          state_d   = ST_FIRST;
        end else if (next_any) begin
          ram_re    = 1'b1;
          ram_raddr = next_word;
          word_d    = next_word;
          state_d   = ST_NEXT;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_FIRST: begin
        if (first_masked != '0) begin
          res_found_d = 1'b1;
          res_free_d  = CLASS_W'({cls_word, low_bit_pos(first_masked)});
          state_d     = ST_EMIT;
        end else if (next_any) begin
          ram_re    = 1'b1;
          ram_raddr = next_word;
          word_d    = next_word;
          state_d   = ST_NEXT;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_NEXT: begin
        res_found_d = 1'b1;
        res_free_d  = CLASS_W'({word_q, low_bit_pos(ram_rdata)});
        state_d     = ST_EMIT;
      end
      ST_SETRD: begin
        ram_we              = 1'b1;
        summary_d[set_word] = (new_word != '0);
        state_d             = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      summary_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      summary_q <= summary_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      op_q       <= s_axis_tuser[0];
      size_q     <= s_axis_tdata[39:0];
      idx_q      <= s_axis_tdata[50:40];
      nonempty_q <= s_axis_tdata[51];
    end
    class_q     <= class_d;
    word_q      <= word_d;
    res_class_q <= res_class_d;
    res_found_q <= res_found_d;
    res_free_q  <= res_free_d;
    if (out_load) begin
      m_class_q <= res_class_q;
      m_found_q <= res_found_q;
      m_free_q  <= res_free_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_free_q, m_class_q};
  assign m_axis_tuser  = m_found_q;

  // class bitmap words
  fcbf_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== src/fcbf_ram.sv =====
// ----------------------------------------------------------------------------
// fcbf_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fcbf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
